>>> hw/rtl/delta_byte_encoder_macros.svh
// ----------------------------------------------------------------------------
// delta byte encoder assertion macros
// concurrent assertion forms for the encoder rtl, used by dbe_pack
// ----------------------------------------------------------------------------
`ifndef DELTA_BYTE_ENCODER_MACROS_SVH
`define DELTA_BYTE_ENCODER_MACROS_SVH

// same-cycle implication, disabled in reset
`define DBE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/dbe_pkg.sv
// ----------------------------------------------------------------------------
// dbe_pkg
// types and constants shared by the delta byte encoder modules
// ----------------------------------------------------------------------------
package dbe_pkg;

    localparam int SAMPLE_W = 32;
    localparam int BYTE_W   = 8;
    localparam int MAX_BYTES = 5;
    localparam int CNT_W    = 3;

    localparam logic [BYTE_W-1:0]   ESCAPE_BYTE = 8'hFF;
    localparam logic [SAMPLE_W-1:0] POS_LIMIT   = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] NEG_LIMIT   = 32'h8000_0000;

    localparam logic [CNT_W-1:0] CNT_SHORT = 3'd1;
    localparam logic [CNT_W-1:0] CNT_ABS   = 3'd4;
    localparam logic [CNT_W-1:0] CNT_LONG  = 3'd5;

    // product beat from the quantizer to the packer
    typedef struct packed {
        logic [SAMPLE_W-1:0] q_mag;
        logic                neg;
        logic                first;
    } quant_beat_t;

endpackage

>>> hw/rtl/delta_byte_encoder.sv
// ----------------------------------------------------------------------------
// delta_byte_encoder
// quantizes q16.16 samples and emits a delta byte stream with escape byte
//
//   channel   dir  tdata                 tuser            tlast
//   s_*       in   sample [31:0]         first_of_block   -
//   m_*       out  code_byte [7:0]       -                last_of_item
//   cfg_*     in   inv_precision [31:0]  -                -
//
// one byte leaves per cycle on m_* while m_tready is high and an item is waiting; an item is 1, 4 or 5 bytes
// s_* takes a new beat every cycle while short deltas flow and m_tready stays high
// an input beat passes the input, product and output buffer registers before its first byte appears
// reset clears valids, previous value to 0 and inv_precision to 1.0
// stalls on m_* back up through the product and input registers
// ----------------------------------------------------------------------------
module delta_byte_encoder
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dbe_pkg::SAMPLE_W-1:0]   s_tdata,   // sample [31:0]
    input  logic                           s_tuser,   // first_of_block [0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dbe_pkg::BYTE_W-1:0]     m_tdata,   // code_byte [7:0]
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [dbe_pkg::SAMPLE_W-1:0]   cfg_wdata
);

    localparam logic [dbe_pkg::SAMPLE_W-1:0] INV_RESET = 32'h0001_0000;

    logic [dbe_pkg::SAMPLE_W-1:0] inv_precision_reg;
    logic                         q_valid;
    logic                         q_ready;
    dbe_pkg::quant_beat_t         q_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inv_precision_reg <= INV_RESET;
        else if (cfg_we)
            inv_precision_reg <= cfg_wdata;
    end

    dbe_quant u_quant
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .inv_precision (inv_precision_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_beat        (q_beat)
    );

    dbe_pack u_pack
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_beat   (q_beat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> hw/rtl/dbe_quant.sv
// ----------------------------------------------------------------------------
// dbe_quant
// input register and magnitude multiply by the reciprocal step
// ----------------------------------------------------------------------------
module dbe_quant
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dbe_pkg::SAMPLE_W-1:0]   s_tdata,
    input  logic                           s_tuser,
    input  logic [dbe_pkg::SAMPLE_W-1:0]   inv_precision,
    output logic                           q_valid,
    input  logic                           q_ready,
    output dbe_pkg::quant_beat_t           q_beat
);

    logic                           in_valid_reg;
    logic [dbe_pkg::SAMPLE_W-1:0]   raw_reg;
    logic                           first_reg;
    logic                           prod_valid_reg;
    dbe_pkg::quant_beat_t           prod_reg;
    dbe_pkg::quant_beat_t           prod_next;
    logic                           stage2_ready;
    logic                           raw_neg;
    logic [dbe_pkg::SAMPLE_W-1:0]   mag;
    logic [2*dbe_pkg::SAMPLE_W-1:0] product;

    assign stage2_ready = !prod_valid_reg || q_ready;
    assign s_tready     = !in_valid_reg || stage2_ready;

    assign raw_neg = raw_reg[dbe_pkg::SAMPLE_W-1];
    assign mag     = raw_neg ? (~raw_reg + 1'b1) : raw_reg;
    assign product = {{dbe_pkg::SAMPLE_W{1'b0}}, mag} *
                     {{dbe_pkg::SAMPLE_W{1'b0}}, inv_precision};

    always_comb
    begin
        prod_next.q_mag = product[2*dbe_pkg::SAMPLE_W-1:dbe_pkg::SAMPLE_W];
        prod_next.neg   = raw_neg;
        prod_next.first = first_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (stage2_ready)
                prod_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            raw_reg   <= s_tdata;
            first_reg <= s_tuser;
        end
        if (in_valid_reg && stage2_ready)
            prod_reg <= prod_next;
    end

    assign q_valid = prod_valid_reg;
    assign q_beat  = prod_reg;

endmodule

>>> hw/rtl/dbe_pack.sv
// ----------------------------------------------------------------------------
// dbe_pack
// saturation, delta against the previous value and byte serializer
// ----------------------------------------------------------------------------
`include "delta_byte_encoder_macros.svh"

module dbe_pack
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  dbe_pkg::quant_beat_t           q_beat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dbe_pkg::BYTE_W-1:0]     m_tdata,
    output logic                           m_tlast
);

    localparam int BUF_W = dbe_pkg::MAX_BYTES * dbe_pkg::BYTE_W;

    logic                           out_valid_reg;
    logic [dbe_pkg::CNT_W-1:0]      cnt_reg;
    logic [dbe_pkg::CNT_W-1:0]      cnt_next;
    logic [BUF_W-1:0]               buf_reg;
    logic [BUF_W-1:0]               buf_next;
    logic [dbe_pkg::SAMPLE_W-1:0]   prev_reg;
    logic [dbe_pkg::SAMPLE_W-1:0]   q_sat;
    logic [dbe_pkg::SAMPLE_W-1:0]   cur;
    logic [dbe_pkg::SAMPLE_W-1:0]   delta;
    logic                           short_ok;
    logic                           load;
    logic                           take;

    // clamp and restore the sign
    always_comb
    begin
        if (q_beat.neg)
        begin
            q_sat = (q_beat.q_mag > dbe_pkg::NEG_LIMIT) ? dbe_pkg::NEG_LIMIT : q_beat.q_mag;
            cur   = ~q_sat + 1'b1;
        end
        else
        begin
            q_sat = (q_beat.q_mag > dbe_pkg::POS_LIMIT) ? dbe_pkg::POS_LIMIT : q_beat.q_mag;
            cur   = q_sat;
        end
    end

    assign delta    = cur - prev_reg;
    // -128..127 except -1
    assign short_ok = (delta[dbe_pkg::SAMPLE_W-1:7] == '0) ||
                      ((&delta[dbe_pkg::SAMPLE_W-1:7]) && !(&delta[6:0]));

    always_comb
    begin
        if (q_beat.first)
        begin
            buf_next = {cur, {dbe_pkg::BYTE_W{1'b0}}};
            cnt_next = dbe_pkg::CNT_ABS;
        end
        else if (short_ok)
        begin
            buf_next = {delta[dbe_pkg::BYTE_W-1:0], {dbe_pkg::SAMPLE_W{1'b0}}};
            cnt_next = dbe_pkg::CNT_SHORT;
        end
        else
        begin
            buf_next = {dbe_pkg::ESCAPE_BYTE, delta};
            cnt_next = dbe_pkg::CNT_LONG;
        end
    end

    assign take    = out_valid_reg && m_tready;
    assign q_ready = !out_valid_reg || (take && (cnt_reg == dbe_pkg::CNT_SHORT));
    assign load    = q_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            prev_reg      <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            cnt_reg       <= cnt_next;
            prev_reg      <= cur;
        end
        else if (take)
        begin
            out_valid_reg <= (cnt_reg != dbe_pkg::CNT_SHORT);
            cnt_reg       <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= buf_next;
        else if (take)
            buf_reg <= {buf_reg[BUF_W-dbe_pkg::BYTE_W-1:0], {dbe_pkg::BYTE_W{1'b0}}};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = buf_reg[BUF_W-1:BUF_W-dbe_pkg::BYTE_W];
    assign m_tlast  = (cnt_reg == dbe_pkg::CNT_SHORT);

    `DBE_ASSERT_SAME(a_cnt_range, clk, rst_n, out_valid_reg,
        (cnt_reg != '0) && (cnt_reg <= dbe_pkg::CNT_LONG), "byte count out of range")
    `DBE_ASSERT_NEXT(a_escape_first, clk, rst_n, load && !q_beat.first && !short_ok,
        m_tdata == dbe_pkg::ESCAPE_BYTE, "long form does not open with escape")
    `DBE_ASSERT_NEXT(a_more_bytes, clk, rst_n, take && !m_tlast,
        m_tvalid, "beat missing inside an item")

endmodule

>>> dv/delta_byte_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_byte_encoder_tb
// self-checking bench for the delta byte encoder: a directed table of
// samples and step writes, then random phases under several step settings.
// every accepted sample is run through a local quantizer and delta coder
// and its expected code bytes, or the typed ones of a directed row, are matched against the output stream.
// ----------------------------------------------------------------------------
module delta_byte_encoder_tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SHORT_LO       = -128;
    localparam int SHORT_HI       = 127;
    localparam int IDLE_PCT       = 33;
    localparam int STEP_PAUSE     = 8;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 42;
    localparam int NUM_PHASES     = 6;
    localparam int STEADY_PHASE   = 2;

    typedef enum logic {ROW_SAMPLE, ROW_STEP} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        fob;
        logic [31:0] value;
        logic [2:0]  n_typed;
        logic [39:0] typed;    // bytes right-aligned, first byte highest
    } stim_row_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } code_beat_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // sample [31:0]
    logic        s_tuser = 1'b0;   // first_of_block [0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // code_byte [7:0]
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    logic [31:0] step_inv = 32'h0001_0000;
    logic [31:0] last_quant = '0;
    logic        steady = 1'b0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    code_beat_t  pending_codes [$];
    stim_row_t   dir_rows [$];

    delta_byte_encoder uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void add_row(input stim_row_t r);
        begin
            dir_rows.insert(dir_rows.size(), r);
        end
    endfunction

    function automatic void add_code(input code_beat_t b);
        begin
            pending_codes.insert(pending_codes.size(), b);
        end
    endfunction

    function automatic logic [31:0] quantize_sample(input logic [31:0] raw,
                                                    input logic [31:0] inv);
        logic [31:0] mag;
        logic [63:0] prod;
        logic [31:0] q;
        begin
            mag  = raw[31] ? (~raw + 32'd1) : raw;
            prod = {32'd0, mag} * {32'd0, inv};
            q    = prod[63:32];
            if (!raw[31])
                return (q > dbe_pkg::POS_LIMIT) ? dbe_pkg::POS_LIMIT : q;
            if (q > dbe_pkg::NEG_LIMIT)
                q = dbe_pkg::NEG_LIMIT;
            return ~q + 32'd1;
        end
    endfunction

    // byte count and bytes for one sample, advances the previous value
    task automatic encode_sample(input logic [31:0] raw, input logic fob,
                                 output logic [2:0] n, output logic [39:0] bytes);
        logic [31:0] cur;
        logic [31:0] delta;
        begin
            cur   = quantize_sample(raw, step_inv);
            delta = cur - last_quant;
            if (fob)
            begin
                n     = dbe_pkg::CNT_ABS;
                bytes = {8'h00, cur};
            end
            else if ($signed(delta) >= SHORT_LO && $signed(delta) <= SHORT_HI
                     && delta != 32'hFFFF_FFFF)
            begin
                n     = dbe_pkg::CNT_SHORT;
                bytes = {32'h0, delta[7:0]};
            end
            else
            begin
                n     = dbe_pkg::CNT_LONG;
                bytes = {dbe_pkg::ESCAPE_BYTE, delta};
            end
            last_quant = cur;
        end
    endtask

    function automatic stim_row_t sample_row(input logic [31:0] smp, input logic fob,
                                             input logic [2:0] n_typed,
                                             input logic [39:0] typed);
        stim_row_t r;
        begin
            r.kind    = ROW_SAMPLE;
            r.fob     = fob;
            r.value   = smp;
            r.n_typed = n_typed;
            r.typed   = typed;
            return r;
        end
    endfunction

    function automatic stim_row_t step_row(input logic [31:0] inv);
        stim_row_t r;
        begin
            r         = '0;
            r.kind    = ROW_STEP;
            r.value   = inv;
            return r;
        end
    endfunction

    task automatic send_sample(input logic [31:0] smp, input logic fob,
                               input logic [2:0] n_typed, input logic [39:0] typed);
        logic [2:0]  n;
        logic [39:0] bytes;
        code_beat_t  b;
        int          cnt;
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= smp;
            s_tuser  <= fob;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            encode_sample(smp, fob, n, bytes);
            if (n_typed != 3'd0)
            begin
                n     = n_typed;
                bytes = typed;
            end
            cnt = n;
            for (int i = 0; i < cnt; i++)
            begin
                b.code = bytes[8*(cnt-1-i) +: 8];
                b.last = (i == cnt - 1);
                add_code(b);
            end
            if (!steady && $urandom_range(0, 99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 2)) @(posedge clk);
            end
        end
    endtask

    // step register changes only once the stream has drained
    task automatic write_step_inv(input logic [31:0] inv);
        begin
            s_tvalid <= 1'b0;
            while (pending_codes.size() != 0)
                @(posedge clk);
            repeat (STEP_PAUSE) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= inv;
            @(posedge clk);
            step_inv = inv;
            cfg_we <= 1'b0;
        end
    endtask

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        code_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_codes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: code_byte %h last_of_item %b",
                             m_tdata, m_tlast);
            end
            else
            begin
                want = pending_codes.pop_front();
                if (m_tdata !== want.code || m_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"beat mismatch: code_byte exp %h got %h, ",
                                  "last_of_item exp %b got %b"},
                                 want.code, m_tdata, want.last, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("delta_byte_encoder_tb: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [31:0] phase_steps [NUM_PHASES];
        logic [31:0] smp;
        logic [31:0] prev_smp;
        logic        fob;
        int          pick;
        int          off;

        // no block start yet, so deltas run against zero
        add_row(sample_row(32'h0005_0000, 1'b0, 3'd1, 40'h05));
        add_row(sample_row(32'h0001_0000, 1'b1, 3'd4, 40'h00_0000_0001));
        // delta of minus one takes the long form
        add_row(sample_row(32'h0000_0000, 1'b0, 3'd5, 40'hFF_FFFF_FFFF));
        add_row(sample_row(32'h007F_0000, 1'b0, 3'd1, 40'h7F));
        add_row(sample_row(32'hFFFF_0000, 1'b0, 3'd1, 40'h80));
        add_row(sample_row(32'h7FFF_FFFF, 1'b0, 3'd0, 40'h0));
        add_row(sample_row(32'h8000_0000, 1'b1, 3'd4, 40'h00_FFFF_8000));
        add_row(sample_row(32'hFFFF_8000, 1'b0, 3'd0, 40'h0));
        add_row(sample_row(32'h0000_0000, 1'b1, 3'd4, 40'h00_0000_0000));
        add_row(sample_row(32'hFF7F_0000, 1'b0, 3'd5, 40'hFF_FFFF_FF7F));
        add_row(sample_row(32'hFFFF_0000, 1'b0, 3'd5, 40'hFF_0000_0080));
        add_row(step_row(32'hFFFF_FFFF));
        add_row(sample_row(32'h7FFF_FFFF, 1'b1, 3'd0, 40'h0));
        add_row(sample_row(32'h8000_0000, 1'b0, 3'd0, 40'h0));
        add_row(sample_row(32'h0000_0001, 1'b0, 3'd0, 40'h0));
        add_row(step_row(32'h0000_0001));
        add_row(sample_row(32'h7FFF_FFFF, 1'b1, 3'd4, 40'h00_0000_0000));
        add_row(sample_row(32'h8000_0000, 1'b0, 3'd1, 40'h00));
        // zero step register quantizes everything to zero
        add_row(step_row(32'h0000_0000));
        add_row(sample_row(32'h1234_5678, 1'b1, 3'd4, 40'h00_0000_0000));
        add_row(sample_row(32'hFFFF_FFFF, 1'b0, 3'd1, 40'h00));
        add_row(sample_row(32'h8000_0000, 1'b0, 3'd1, 40'h00));

        phase_steps[0] = 32'h0001_0000;
        phase_steps[1] = $urandom_range(32'h4000, 32'h4_0000);
        phase_steps[2] = 32'hFFFF_FFFF;
        phase_steps[3] = 32'h0000_0001;
        phase_steps[4] = $urandom;
        phase_steps[5] = 32'h0001_0000;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].kind == ROW_STEP)
                write_step_inv(dir_rows[k].value);
            else
                send_sample(dir_rows[k].value, dir_rows[k].fob,
                            dir_rows[k].n_typed, dir_rows[k].typed);
        end

        prev_smp = '0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_step_inv(phase_steps[p]);
            steady = (p == STEADY_PHASE);
            for (int j = 0; j < PHASE_ITEMS; j++)
            begin
                pick = $urandom_range(0, 99);
                fob  = ($urandom_range(0, 99) < 12);
                if (pick < 35)
                begin
                    off = $urandom_range(0, 512);
                    smp = prev_smp + (off - 256);
                end
                else if (pick < 70)
                begin
                    off = $urandom_range(0, 300);
                    smp = prev_smp + (off - 150) * 65536;
                end
                else if (pick < 90)
                    smp = $urandom;
                else
                begin
                    case ($urandom_range(0, 3))
                        0: smp = 32'h7FFF_FFFF;
                        1: smp = 32'h8000_0000;
                        2: smp = 32'h0000_0000;
                        default: smp = 32'hFFFF_FFFF;
                    endcase
                end
                prev_smp = smp;
                send_sample(smp, fob, 3'd0, 40'h0);
            end
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_codes.size() == 0)
            $display("delta_byte_encoder_tb: done, clean");
        else
            $display("delta_byte_encoder_tb: done, errors");
        $finish;
    end

endmodule
